[rtl/rgb_hsv_color_convert_macros.svh]
// Assertion macros for the checker file of the color converter.
`ifndef RGB_HSV_COLOR_CONVERT_MACROS_SVH
`define RGB_HSV_COLOR_CONVERT_MACROS_SVH

// Check on every clock edge outside reset.
`define RHCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define RHCC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/rhcc_pkg.sv]
// Types, constants and arithmetic helpers of the RGB/HSV color converter.
package rhcc_pkg;

    localparam int CHAN_W      = 8;
    localparam int DIV_STAGES  = 8;
    localparam int DIV_W       = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;
    localparam logic [CHAN_W-1:0] HUE_SECTOR  = 8'd43;
    localparam logic [CHAN_W-1:0] REM_SCALE   = 8'd6;
    localparam logic [CHAN_W-1:0] HUE_BASE_R  = 8'd0;
    localparam logic [CHAN_W-1:0] HUE_BASE_G  = 8'd85;
    localparam logic [CHAN_W-1:0] HUE_BASE_B  = 8'd171;

    typedef enum logic [2:0] {
        REG_RED_YEL  = 3'd0,
        REG_YEL_GRN  = 3'd1,
        REG_GRN_CYN  = 3'd2,
        REG_CYN_BLU  = 3'd3,
        REG_BLU_MAG  = 3'd4,
        REG_MAG_RED  = 3'd5
    } t_region;

    typedef logic [CHAN_W-1:0] t_chan;

    typedef struct packed {
        t_chan a;
        t_chan b;
        t_chan c;
    } t_pix;

    typedef struct packed {
        logic             dir;
        logic             grey;
        logic             neg;
        t_chan            base;
        t_chan            hi;
        t_chan            span;
        logic [DIV_W-1:0] dsat;
        logic [DIV_W-1:0] dhue;
        t_region          region;
        logic             sz;
        t_chan            v;
        t_chan            x;
        t_chan            y;
        t_chan            z;
    } t_stg;

    // (a * b) >> 8
    function automatic t_chan mul_shr(input t_chan a, input t_chan b);
        logic [DIV_W-1:0] pr;
        pr = DIV_W'(a) * DIV_W'(b);
        return pr[DIV_W-1:CHAN_W];
    endfunction

    // One restoring division step: partial remainder in the upper half,
    // dividend bits shift out of the lower half as quotient bits shift in.
    function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
                                                  input t_chan d);
        logic [CHAN_W:0]   t;
        logic [CHAN_W:0]   df;
        logic [CHAN_W-1:0] up;
        logic              qb;
        t  = {w[DIV_W-1:CHAN_W], w[CHAN_W-1]};
        df = t - {1'b0, d};
        qb = (t >= {1'b0, d});
        up = qb ? df[CHAN_W-1:0] : t[CHAN_W-1:0];
        return {up, w[CHAN_W-2:0], qb};
    endfunction

endpackage

[rtl/rgb_hsv_color_convert.sv]
// Pipelined RGB/HSV pixel converter, one pixel per clock.
//
//  channel   dir  handshake                  payload (low bits first)
//  s_axis    in   i_s_axis_tvalid/o_..tready chan_a, chan_b, chan_c
//  m_axis    out  o_m_axis_tvalid/i_..tready out_a, out_b, out_c
//  cfg       in   i_cfg_valid/o_cfg_ready    direction
//
//  Throughput one pixel per cycle unless m_axis stalls; the registers are the input
//  register, preprocessing, eight quotient-bit stages of the dividers, output register.
//  Reset clears all valid bits and sets direction to HSV to RGB.
//  A stall on m_axis freezes the whole pipeline and drops s_axis tready.
module rgb_hsv_color_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,    // chan_a, chan_b, chan_c
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,    // out_a, out_b, out_c
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data         // direction
);
    import rhcc_pkg::*;

    logic               w_en;
    logic               r_dir;
    logic               r_dir0;
    t_pix               r_in;
    t_stg               r_st1;
    t_stg               n_st1;
    t_stg               r_stg [DIV_STAGES];
    t_stg               n_stg [DIV_STAGES];
    t_pix               r_out;
    t_pix               n_out;
    logic [DIV_STAGES+1:0] r_vld;
    logic               r_ovld;

    assign w_en            = !r_ovld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {r_out.c, r_out.b, r_out.a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
        end else if (i_cfg_valid) begin
            r_dir <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[DIV_STAGES:0], i_s_axis_tvalid};
            r_ovld <= r_vld[DIV_STAGES+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in.a <= i_s_axis_tdata[7:0];
            r_in.b <= i_s_axis_tdata[15:8];
            r_in.c <= i_s_axis_tdata[23:16];
            r_dir0 <= r_dir;
            r_st1  <= n_st1;
            r_out  <= n_out;
        end
    end

    always_comb begin
        t_chan             hi;
        t_chan             lo;
        logic [CHAN_W:0]   diff;
        t_chan             mag;
        t_chan             rbase;
        t_chan             roff;
        n_st1     = '0;
        n_st1.dir = r_dir0;
        hi = (r_in.a >= r_in.b) ? r_in.a : r_in.b;
        hi = (hi >= r_in.c) ? hi : r_in.c;
        lo = (r_in.a <= r_in.b) ? r_in.a : r_in.b;
        lo = (lo <= r_in.c) ? lo : r_in.c;
        if (hi == r_in.a) begin
            n_st1.base = HUE_BASE_R;
            diff = {1'b0, r_in.b} - {1'b0, r_in.c};
        end else if (hi == r_in.b) begin
            n_st1.base = HUE_BASE_G;
            diff = {1'b0, r_in.c} - {1'b0, r_in.a};
        end else begin
            n_st1.base = HUE_BASE_B;
            diff = {1'b0, r_in.a} - {1'b0, r_in.b};
        end
        n_st1.neg  = diff[CHAN_W];
        mag        = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
        n_st1.hi   = hi;
        n_st1.span = hi - lo;
        n_st1.grey = (hi == lo);
        n_st1.dsat = {n_st1.span, {CHAN_W{1'b0}}} - DIV_W'(n_st1.span);
        n_st1.dhue = DIV_W'(mag) * DIV_W'(HUE_SECTOR);

        case (r_in.a) inside
            [8'd0:8'd42]: begin
                n_st1.region = REG_RED_YEL;
                rbase = 8'd0;
            end
            [8'd43:8'd85]: begin
                n_st1.region = REG_YEL_GRN;
                rbase = 8'd43;
            end
            [8'd86:8'd128]: begin
                n_st1.region = REG_GRN_CYN;
                rbase = 8'd86;
            end
            [8'd129:8'd171]: begin
                n_st1.region = REG_CYN_BLU;
                rbase = 8'd129;
            end
            [8'd172:8'd214]: begin
                n_st1.region = REG_BLU_MAG;
                rbase = 8'd172;
            end
            default: begin
                n_st1.region = REG_MAG_RED;
                rbase = 8'd215;
            end
        endcase
        roff     = r_in.a - rbase;
        n_st1.x  = CHAN_W'(roff * REM_SCALE);
        n_st1.y  = r_in.b;
        n_st1.sz = (r_in.b == '0);
        n_st1.v  = r_in.c;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        t_stg w_prv;

        if (k == 0) begin : g_first
            assign w_prv = r_st1;
        end else begin : g_next
            assign w_prv = r_stg[k-1];
        end

        always_comb begin
            n_stg[k]      = w_prv;
            n_stg[k].dsat = div_step(w_prv.dsat, w_prv.hi);
            n_stg[k].dhue = div_step(w_prv.dhue, w_prv.span);
            if (k == 0) begin
                n_stg[k].x = mul_shr(w_prv.y, w_prv.x);
                n_stg[k].y = mul_shr(w_prv.y, CHAN_MAX - w_prv.x);
                n_stg[k].z = CHAN_MAX - w_prv.y;
            end else if (k == 1) begin
                n_stg[k].x = mul_shr(w_prv.v, CHAN_MAX - w_prv.x);
                n_stg[k].y = mul_shr(w_prv.v, CHAN_MAX - w_prv.y);
                n_stg[k].z = mul_shr(w_prv.v, w_prv.z);
            end else if (k == 2) begin
                // x = q, y = t, z = p
                if (w_prv.sz) begin
                    n_stg[k].x = w_prv.v;
                    n_stg[k].y = w_prv.v;
                    n_stg[k].z = w_prv.v;
                end else begin
                    case (w_prv.region)
                        REG_RED_YEL: begin
                            n_stg[k].x = w_prv.v;
                            n_stg[k].y = w_prv.y;
                            n_stg[k].z = w_prv.z;
                        end
                        REG_YEL_GRN: begin
                            n_stg[k].x = w_prv.x;
                            n_stg[k].y = w_prv.v;
                            n_stg[k].z = w_prv.z;
                        end
                        REG_GRN_CYN: begin
                            n_stg[k].x = w_prv.z;
                            n_stg[k].y = w_prv.v;
                            n_stg[k].z = w_prv.y;
                        end
                        REG_CYN_BLU: begin
                            n_stg[k].x = w_prv.z;
                            n_stg[k].y = w_prv.x;
                            n_stg[k].z = w_prv.v;
                        end
                        REG_BLU_MAG: begin
                            n_stg[k].x = w_prv.y;
                            n_stg[k].y = w_prv.z;
                            n_stg[k].z = w_prv.v;
                        end
                        default: begin
                            n_stg[k].x = w_prv.v;
                            n_stg[k].y = w_prv.z;
                            n_stg[k].z = w_prv.x;
                        end
                    endcase
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_comb begin
        t_stg  last;
        t_chan qh;
        last = r_stg[DIV_STAGES-1];
        qh   = last.dhue[CHAN_W-1:0];
        if (last.dir) begin
            if (last.grey) begin
                n_out.a = '0;
                n_out.b = '0;
            end else begin
                n_out.a = last.neg ? (last.base - qh) : (last.base + qh);
                n_out.b = last.dsat[CHAN_W-1:0];
            end
            n_out.c = last.hi;
        end else begin
            n_out.a = last.x;
            n_out.b = last.y;
            n_out.c = last.z;
        end
    end

endmodule

[rtl/rhcc_chk.sv]
// Port-level checker of the color converter, bound to the top level.
`include "rgb_hsv_color_convert_macros.svh"

module rhcc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);

    `RHCC_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result request dropped while stalled")

    `RHCC_ASSERT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "result data changed while stalled")

    `RHCC_ASSERT(a_rst_empty, $past(!i_rst_n) |-> !o_m_axis_tvalid, "result request right after reset")

    `RHCC_ASSERT(a_in_ready, o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready), "input ready does not follow output stall")

endmodule

bind rgb_hsv_color_convert rhcc_chk u_rhcc_chk (.*);
